FILE: sv/mmcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmcs_pkg
// Shared types and constants of the min-max contrast stretch block.
// ----------------------------------------------------------------------------
package mmcs_pkg;

  // depth of the queue between the front and the back
  localparam int QDEPTH = 2;

  // how the front classified a stretch request
  typedef struct packed {
    logic flat;   // latched range is zero
    logic sat;    // pixel at or above minimum plus range
    logic fend;   // last pixel of the frame
  } flags_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_DONE = 3'b100
  } back_state_t;

endpackage
`default_nettype wire

FILE: sv/mmcs_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmcs_front
// Takes requests, tracks the frame minimum and maximum in the measure pass and
// classifies stretch-pass pixels against the latched minimum and range.
// ----------------------------------------------------------------------------
module mmcs_front #(
  parameter int PIXEL_BITS = 8
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire                    mode,
  input  wire [PIXEL_BITS-1:0]   pixel_in,
  input  wire                    frame_end,
  input  wire                    q_full,
  output logic                   push,
  output logic [PIXEL_BITS-1:0]  push_diff,
  output logic [PIXEL_BITS-1:0]  push_range,
  output mmcs_pkg::flags_t       push_flags
);
  import mmcs_pkg::*;

  localparam logic [PIXEL_BITS-1:0] PMAX = {PIXEL_BITS{1'b1}};

  logic [PIXEL_BITS-1:0] running_low;
  logic [PIXEL_BITS-1:0] running_high;
  logic [PIXEL_BITS-1:0] latched_low;
  logic [PIXEL_BITS-1:0] latched_range;
  logic [PIXEL_BITS-1:0] low_next;
  logic [PIXEL_BITS-1:0] high_next;
  logic                  accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && mode;

  assign low_next  = (pixel_in < running_low)  ? pixel_in : running_low;
  assign high_next = (pixel_in > running_high) ? pixel_in : running_high;

  always_comb begin
    push_range      = latched_range;
    push_diff       = (pixel_in > latched_low) ? (pixel_in - latched_low) : '0;
    push_flags.flat = (latched_range == '0);
    push_flags.sat  = (push_diff >= latched_range);
    push_flags.fend = frame_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_low   <= PMAX;
      running_high  <= '0;
      latched_low   <= '0;
      latched_range <= '0;
    end else if (accept && !mode) begin
      if (frame_end) begin
        latched_low   <= low_next;
        latched_range <= (high_next >= low_next) ? (high_next - low_next) : '0;
        running_low   <= PMAX;
        running_high  <= '0;
      end else begin
        running_low   <= low_next;
        running_high  <= high_next;
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/mmcs_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmcs_queue
// Short queue of classified stretch requests between the front and the back.
// ----------------------------------------------------------------------------
module mmcs_queue #(
  parameter int PIXEL_BITS = 8
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    push,
  input  wire [PIXEL_BITS-1:0]   push_diff,
  input  wire [PIXEL_BITS-1:0]   push_range,
  input  mmcs_pkg::flags_t       push_flags,
  output logic                   full,
  output logic                   empty,
  input  wire                    pop,
  output logic [PIXEL_BITS-1:0]  pop_diff,
  output logic [PIXEL_BITS-1:0]  pop_range,
  output mmcs_pkg::flags_t       pop_flags
);
  import mmcs_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  logic [PIXEL_BITS-1:0] diff_mem  [QDEPTH];
  logic [PIXEL_BITS-1:0] range_mem [QDEPTH];
  flags_t                flags_mem [QDEPTH];
  logic [PTR_W-1:0]      wr_ptr;
  logic [PTR_W-1:0]      rd_ptr;
  logic [CNT_W-1:0]      count;
  logic                  do_push;
  logic                  do_pop;

  assign full    = (count == CNT_W'(QDEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  assign pop_diff  = diff_mem[rd_ptr];
  assign pop_range = range_mem[rd_ptr];
  assign pop_flags = flags_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      diff_mem[wr_ptr]  <= push_diff;
      range_mem[wr_ptr] <= push_range;
      flags_mem[wr_ptr] <= push_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/mmcs_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmcs_back
// Works out pmax*(p-min)/range for queued stretch requests with a restoring
// divider, one quotient bit per cycle, and holds the result in an output
// register.
// ----------------------------------------------------------------------------
module mmcs_back #(
  parameter int PIXEL_BITS = 8
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    q_empty,
  output logic                   pop,
  input  wire [PIXEL_BITS-1:0]   pop_diff,
  input  wire [PIXEL_BITS-1:0]   pop_range,
  input  mmcs_pkg::flags_t       pop_flags,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic [PIXEL_BITS-1:0]  pixel_out,
  output logic                   flat_frame,
  output logic                   end_out
);
  import mmcs_pkg::*;

  localparam int P     = PIXEL_BITS;
  localparam int CNT_W = $clog2(P);
  localparam logic [P-1:0] PMAX = {P{1'b1}};

  back_state_t      state;
  logic [P-1:0]     rem;
  logic [P-1:0]     low_bits;
  logic [P-1:0]     quot;
  logic [P-1:0]     divisor;
  logic [CNT_W-1:0] cnt;
  logic             flat;
  logic             fend;
  logic [2*P-1:0]   numer;
  logic [P:0]       trial;
  logic             qbit;
  logic             out_free;

  assign pop      = (state == S_IDLE) && !q_empty;
  assign out_free = !out_valid || out_ready;

  // pmax*diff as (diff << P) - diff
  assign numer = {pop_diff, {P{1'b0}}} - {{P{1'b0}}, pop_diff};
  assign trial = {rem, low_bits[P-1]};
  assign qbit  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cnt <= '0;
            if (pop_flags.flat || pop_flags.sat) begin
              state <= S_DONE;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(P - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        rem      <= numer[2*P-1:P];
        low_bits <= numer[P-1:0];
        divisor  <= pop_range;
        flat     <= pop_flags.flat;
        fend     <= pop_flags.fend;
        quot     <= pop_flags.flat ? '0 : (pop_flags.sat ? PMAX : '0);
      end
      S_DIV: begin
        rem      <= qbit ? P'(trial - {1'b0, divisor}) : trial[P-1:0];
        low_bits <= {low_bits[P-2:0], 1'b0};
        quot     <= {quot[P-2:0], qbit};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      pixel_out  <= quot;
      flat_frame <= flat;
      end_out    <= fend;
    end
  end

endmodule
`default_nettype wire

FILE: sv/min_max_contrast_stretch.sv
`default_nettype none
// ----------------------------------------------------------------------------
// min_max_contrast_stretch
// Min-max contrast stretch of a grey frame streamed twice.
// ----------------------------------------------------------------------------
// A frame is sent twice. Requests with mode 0 (measure pass) track the lowest
// and highest pixel; the one with frame_end latches minimum and range and
// starts a fresh measure. Requests with mode 1 (stretch pass) give one result
// each, pmax*(p-min)/range floored and clamped to 0..pmax, or 0 with
// flat_frame set when the latched range is zero. Measure requests are taken
// one per clock while the queue has room. A stretch request that needs a
// division passes load, the one-bit-per-cycle divider of the back end and
// hand-over in turn; clamped and flat pixels skip the divider. A two-entry
// queue lets the front keep taking requests while the divider works.
module min_max_contrast_stretch #(
  parameter int PIXEL_BITS = 8
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire                    mode,
  input  wire [PIXEL_BITS-1:0]   pixel_in,
  input  wire                    frame_end,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic [PIXEL_BITS-1:0]  pixel_out,
  output logic                   flat_frame,
  output logic                   end_out
);
  import mmcs_pkg::*;

  logic                  push;
  logic [PIXEL_BITS-1:0] push_diff;
  logic [PIXEL_BITS-1:0] push_range;
  flags_t                push_flags;
  logic                  q_full;
  logic                  q_empty;
  logic                  pop;
  logic [PIXEL_BITS-1:0] pop_diff;
  logic [PIXEL_BITS-1:0] pop_range;
  flags_t                pop_flags;

  mmcs_front #(.PIXEL_BITS(PIXEL_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .pixel_in   (pixel_in),
    .frame_end  (frame_end),
    .q_full     (q_full),
    .push       (push),
    .push_diff  (push_diff),
    .push_range (push_range),
    .push_flags (push_flags)
  );

  mmcs_queue #(.PIXEL_BITS(PIXEL_BITS)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_diff  (push_diff),
    .push_range (push_range),
    .push_flags (push_flags),
    .full       (q_full),
    .empty      (q_empty),
    .pop        (pop),
    .pop_diff   (pop_diff),
    .pop_range  (pop_range),
    .pop_flags  (pop_flags)
  );

  mmcs_back #(.PIXEL_BITS(PIXEL_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .pop        (pop),
    .pop_diff   (pop_diff),
    .pop_range  (pop_range),
    .pop_flags  (pop_flags),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_out  (pixel_out),
    .flat_frame (flat_frame),
    .end_out    (end_out)
  );

endmodule
`default_nettype wire

FILE: sv/mmcs_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmcs_checker
// Port-level checks of the min-max contrast stretch block.
// ----------------------------------------------------------------------------
module mmcs_checker #(
  parameter int PIXEL_BITS = 8
) (
  input wire                   clk,
  input wire                   rst,
  input wire                   in_ready,
  input wire                   out_valid,
  input wire                   out_ready,
  input wire [PIXEL_BITS-1:0]  pixel_out,
  input wire                   flat_frame,
  input wire                   end_out
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_out)
      && $stable(flat_frame) && $stable(end_out))
    else $error("stalled result changed");

  // a flat frame always stretches to black
  a_flat_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && flat_frame |-> pixel_out == '0)
    else $error("flat frame gave a non-zero pixel");

  // queue is empty after reset, so requests are taken
  a_ready_after_rst: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("not ready after reset");

  // no result straight out of reset
  a_no_out_after_rst: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown after reset");

endmodule

bind min_max_contrast_stretch mmcs_checker #(.PIXEL_BITS(PIXEL_BITS)) u_mmcs_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .pixel_out  (pixel_out),
  .flat_frame (flat_frame),
  .end_out    (end_out)
);
`default_nettype wire
